// ----- rtl/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants
// Item formats, opcodes, controller states and control/status bundles
// for the square matrix multiply core.
// ----------------------------------------------------------------------------
package smm_pkg;

	localparam int MAX_DIMENSION = 16;
	localparam int IDX_W         = $clog2(MAX_DIMENSION);
	localparam int ADDR_W        = 2 * IDX_W;
	localparam int DEPTH         = MAX_DIMENSION * MAX_DIMENSION;
	localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
	localparam int ELEM_W        = 32;
	localparam int ACC_W         = 64;
	localparam int FRAC_W        = 16;

	typedef enum logic [1:0] {
		OP_LOAD_LEFT  = 2'd0,
		OP_LOAD_RIGHT = 2'd1,
		OP_COMPUTE    = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         column_index;
		logic signed [ELEM_W-1:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] result_value;
		logic [IDX_W-1:0]        result_row;
		logic [IDX_W-1:0]        result_column;
		logic                    status;
	} out_item_t;

	typedef struct packed {
		logic             wr_left;
		logic             wr_right;
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] k;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic             in_range;
		logic             pipe_busy;
		logic             out_free;
		logic [DIM_W-1:0] dim;
	} stat_t;

endpackage

// ----- rtl/smm_ctrl.sv -----
// ----------------------------------------------------------------------------
// smm_ctrl: sequencing controller
// Decodes items, steps the dot-product index and hands results to the
// output register.
// ----------------------------------------------------------------------------
module smm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         opcode,
	output logic               in_stall,
	input  smm_pkg::stat_t     status,
	output smm_pkg::cmd_t      cmd
);

	smm_pkg::state_t             state_q, state_d;
	logic [smm_pkg::IDX_W-1:0]   k_q, k_d;
	logic                        accept;
	logic                        last;

	assign in_stall = (state_q != smm_pkg::ST_IDLE);
	assign accept   = in_valid && (state_q == smm_pkg::ST_IDLE);
	assign last     = ({1'b0, k_q} == (status.dim - smm_pkg::DIM_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smm_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		cmd          = '0;
		cmd.k        = k_q;
		case (state_q)
			smm_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						smm_pkg::OP_LOAD_LEFT:  cmd.wr_left  = status.in_range;
						smm_pkg::OP_LOAD_RIGHT: cmd.wr_right = status.in_range;
						smm_pkg::OP_COMPUTE: begin
							cmd.start = 1'b1;
							k_d       = '0;
							// out-of-range request skips straight to the result
							state_d   = status.in_range ? smm_pkg::ST_MAC : smm_pkg::ST_FINISH;
						end
						default: ;
					endcase
				end
			end
			smm_pkg::ST_MAC: begin
				cmd.rd_en = 1'b1;
				if (last) begin
					state_d = smm_pkg::ST_DRAIN;
				end else begin
					k_d = k_q + smm_pkg::IDX_W'(1);
				end
			end
			smm_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = smm_pkg::ST_FINISH;
				end
			end
			smm_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = smm_pkg::ST_IDLE;
				end
			end
			default: state_d = smm_pkg::ST_IDLE;
		endcase
	end

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smm_pkg::ST_IDLE) |-> !status.pipe_busy)
		else $error("pipeline busy while idle");

	a_load_out_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !status.pipe_busy)
		else $error("result taken before accumulation finished");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smm_pkg::ST_MAC) |-> ({1'b0, k_q} < status.dim))
		else $error("index beyond dimension in use");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == smm_pkg::ST_IDLE))
		else $error("controller did not return to idle after result");

endmodule

// ----- rtl/smm_datapath.sv -----
// ----------------------------------------------------------------------------
// smm_datapath: element stores and multiply-accumulate path
// Two 256-entry stores, registered read, registered multiply, 64-bit
// accumulator and the output register.
// ----------------------------------------------------------------------------
module smm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smm_pkg::in_item_t           in_item,
	input  logic                        cfg_valid,
	input  logic [smm_pkg::DIM_W-1:0]   cfg_data,
	input  smm_pkg::cmd_t               cmd,
	output smm_pkg::stat_t              status,
	output logic                        out_valid,
	input  logic                        out_stall,
	output smm_pkg::out_item_t          out_item
);

	logic [smm_pkg::ELEM_W-1:0]        left_mem  [smm_pkg::DEPTH];
	logic [smm_pkg::ELEM_W-1:0]        right_mem [smm_pkg::DEPTH];

	logic [smm_pkg::DIM_W-1:0]         dim_q;
	logic [smm_pkg::IDX_W-1:0]         row_q, col_q;
	logic                              inside_q;
	logic signed [smm_pkg::ELEM_W-1:0] a_s1, b_s1;
	logic                              v_s1, v_s2;
	logic signed [smm_pkg::ACC_W-1:0]  prod_s2;
	logic signed [smm_pkg::ACC_W-1:0]  acc_q;
	logic signed [smm_pkg::ACC_W-1:0]  term;
	logic [smm_pkg::ADDR_W-1:0]        wr_addr;
	logic                              out_valid_q;
	smm_pkg::out_item_t                out_q;

	assign wr_addr = {in_item.row_index, in_item.column_index};

	assign status.in_range  = ({1'b0, in_item.row_index} < dim_q)
	                       && ({1'b0, in_item.column_index} < dim_q);
	assign status.pipe_busy = v_s1 || v_s2;
	assign status.out_free  = !out_valid_q || !out_stall;
	assign status.dim       = dim_q;

	// product floored to Q.16
	assign term = {{smm_pkg::FRAC_W{prod_s2[smm_pkg::ACC_W-1]}},
	               prod_s2[smm_pkg::ACC_W-1:smm_pkg::FRAC_W]};

	// configuration register, saturated to 1..MAX_DIMENSION
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= smm_pkg::DIM_W'(smm_pkg::MAX_DIMENSION);
		end else if (cfg_valid) begin
			if (cfg_data == '0)
				dim_q <= smm_pkg::DIM_W'(1);
			else if (cfg_data > smm_pkg::DIM_W'(smm_pkg::MAX_DIMENSION))
				dim_q <= smm_pkg::DIM_W'(smm_pkg::MAX_DIMENSION);
			else
				dim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_left)
			left_mem[wr_addr] <= in_item.element_value;
		if (cmd.wr_right)
			right_mem[wr_addr] <= in_item.element_value;
	end

	always_ff @(posedge clk) begin
		a_s1 <= left_mem[{row_q, cmd.k}];
		b_s1 <= right_mem[{cmd.k, col_q}];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (cmd.start) begin
			row_q    <= in_item.row_index;
			col_q    <= in_item.column_index;
			inside_q <= status.in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.result_value  <= acc_q;
			out_q.result_row    <= row_q;
			out_q.result_column <= col_q;
			out_q.status        <= !inside_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/square_matrix_multiply_core.sv -----
// ----------------------------------------------------------------------------
// square_matrix_multiply_core: Q16.16 square matrix multiplier
// Loads elements into left/right stores and returns single result
// elements as 64-bit Q48.16 dot products.
//
//   port group          dir  handshake          item
//   in_valid/in_item    in   valid / stall      smm_pkg::in_item_t
//   out_valid/out_item  out  valid / stall      smm_pkg::out_item_t
//   cfg_valid/cfg_data  in   valid / ready      dimension in use, 5 bits
//
// Load items do not stall the input. A compute item stalls the input until
// its result is loaded into the output register: one multiply-accumulate
// per cycle through the single store read port pair, plus read, multiply,
// accumulate and hand-over stages.
// An out-of-range request goes straight to hand-over.
// Reset sets the dimension to 16; the stores hold no defined contents.
// The output register lets the next item in while a result waits; a
// compute item waits in its last state while a held result is stalled.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  smm_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output smm_pkg::out_item_t          out_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [smm_pkg::DIM_W-1:0]   cfg_data
);

	smm_pkg::cmd_t  cmd;
	smm_pkg::stat_t status;

	assign cfg_ready = 1'b1;

	smm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_item.opcode),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	smm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: square matrix multiply core testbench
// Loads elements into both stores, requests result elements and checks each
// returned dot product, position and status against an in-bench predictor.
// A short directed table covers the value extremes, floor rounding, ignored
// loads, out-of-range requests, the unused opcode and dimension saturation.
// Random phases then run at several dimensions under bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         CYCLE_LIMIT   = 1000000;
	localparam int         PHASE_ITEMS   = 40;
	localparam int         STALL_NONE    = 0;
	localparam int         STALL_RANDOM  = 1;
	localparam int         STALL_LONG    = 2;

	typedef enum {ROW_ITEM, ROW_DIM} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		smm_pkg::in_item_t  item;
		logic [4:0]         dim;
		bit                 typed;
		smm_pkg::out_item_t result;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	smm_pkg::in_item_t  in_item;
	logic        out_valid;
	logic        out_stall;
	smm_pkg::out_item_t out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [smm_pkg::DIM_W-1:0] cfg_data;

	square_matrix_multiply_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [31:0] left_elems  [smm_pkg::DEPTH];
	logic [31:0] right_elems [smm_pkg::DEPTH];
	bit          left_loaded [smm_pkg::DEPTH];
	bit          right_loaded[smm_pkg::DEPTH];
	logic [4:0]  dim_setting;
	smm_pkg::out_item_t pending_results[$];

	stim_row_t   directed_rows[$];
	int          burst_left = 0;
	int          fail_count = 0;
	int          checked_count = 0;
	int          cycle_count = 0;
	int          load_count = 0;
	int          request_count = 0;
	int          outside_count = 0;
	int          unused_count = 0;
	int          dim_count = 0;
	smm_pkg::out_item_t wanted;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim();
		if (dim_setting == 0)
			return 1;
		if (dim_setting > smm_pkg::MAX_DIMENSION)
			return smm_pkg::MAX_DIMENSION;
		return int'(dim_setting);
	endfunction

	function automatic smm_pkg::out_item_t dot_element(int r, int c);
		smm_pkg::out_item_t res;
		logic signed [63:0] acc;
		logic signed [63:0] a;
		logic signed [63:0] b;
		int d;
		d = eff_dim();
		acc = '0;
		res.result_row = r[3:0];
		res.result_column = c[3:0];
		if (r < d && c < d) begin
			for (int k = 0; k < d; k++) begin
				a = $signed(left_elems[r * smm_pkg::MAX_DIMENSION + k]);
				b = $signed(right_elems[k * smm_pkg::MAX_DIMENSION + c]);
				// products floor to Q.16 before the exact sum
				acc = acc + ((a * b) >>> smm_pkg::FRAC_W);
			end
			res.status = 1'b0;
		end else begin
			res.status = 1'b1;
		end
		res.result_value = acc;
		return res;
	endfunction

	function automatic void apply_to_stores(smm_pkg::in_item_t it, bit typed,
	                                        smm_pkg::out_item_t typed_res);
		int r;
		int c;
		int d;
		bit inside_dim;
		r = int'(it.row_index);
		c = int'(it.column_index);
		d = eff_dim();
		inside_dim = (r < d) && (c < d);
		case (it.opcode)
		smm_pkg::OP_LOAD_LEFT: begin
			load_count++;
			if (inside_dim) begin
				left_elems[r * smm_pkg::MAX_DIMENSION + c] = it.element_value;
				left_loaded[r * smm_pkg::MAX_DIMENSION + c] = 1'b1;
			end
		end
		smm_pkg::OP_LOAD_RIGHT: begin
			load_count++;
			if (inside_dim) begin
				right_elems[r * smm_pkg::MAX_DIMENSION + c] = it.element_value;
				right_loaded[r * smm_pkg::MAX_DIMENSION + c] = 1'b1;
			end
		end
		smm_pkg::OP_COMPUTE: begin
			request_count++;
			if (!inside_dim)
				outside_count++;
			pending_results.push_back(typed ? typed_res : dot_element(r, c));
		end
		default: unused_count++;
		endcase
	endfunction

	function automatic smm_pkg::in_item_t make_item(logic [1:0] op, int r, int c,
	                                               logic [31:0] v);
		smm_pkg::in_item_t it;
		it.opcode = op;
		it.row_index = r[3:0];
		it.column_index = c[3:0];
		it.element_value = v;
		return it;
	endfunction

	function automatic stim_row_t item_row(logic [1:0] op, int r, int c, logic [31:0] v);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.item = make_item(op, r, c, v);
		row.dim = '0;
		row.typed = 1'b0;
		row.result = '0;
		return row;
	endfunction

	function automatic stim_row_t typed_row(int r, int c, logic [63:0] val, logic st);
		stim_row_t row;
		row = item_row(smm_pkg::OP_COMPUTE, r, c, $urandom);
		row.typed = 1'b1;
		row.result.result_value = val;
		row.result.result_row = r[3:0];
		row.result.result_column = c[3:0];
		row.result.status = st;
		return row;
	endfunction

	function automatic stim_row_t dim_row(logic [4:0] d);
		stim_row_t row;
		row = item_row(OP_UNUSED, 0, 0, 32'h0);
		row.kind = ROW_DIM;
		row.dim = d;
		return row;
	endfunction

	function automatic logic [31:0] rand_element();
		case ($urandom_range(0, 7))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'hFFFF_FFFF;
		3: return 32'h0000_0000;
		4: return $urandom_range(0, 131071);
		5: return -$urandom_range(0, 131071);
		default: return $urandom;
		endcase
	endfunction

	// sends one item in bursts with random gaps; valid stays up inside a burst
	task automatic push_item(smm_pkg::in_item_t it, bit typed,
	                         smm_pkg::out_item_t typed_res);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(1, 8);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		apply_to_stores(it, typed, typed_res);
	endtask

	// holds input until every expected result is back and the core has settled
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dimension(logic [4:0] d);
		quiesce();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		dim_setting = d;
		dim_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// loads any missing row/column element first so no unwritten entry is read
	task automatic request_element(int r, int c);
		int d;
		d = eff_dim();
		if (r < d && c < d) begin
			for (int k = 0; k < d; k++) begin
				if (!left_loaded[r * smm_pkg::MAX_DIMENSION + k])
					push_item(make_item(smm_pkg::OP_LOAD_LEFT, r, k, rand_element()),
					          1'b0, '0);
				if (!right_loaded[k * smm_pkg::MAX_DIMENSION + c])
					push_item(make_item(smm_pkg::OP_LOAD_RIGHT, k, c, rand_element()),
					          1'b0, '0);
			end
		end
		push_item(make_item(smm_pkg::OP_COMPUTE, r, c, $urandom), 1'b0, '0);
	endtask

	// output stall pattern: quiet, random and long-run stretches
	int          stall_mode = STALL_NONE;
	int          mode_left = 0;
	logic [3:0]  stall_phase = '0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
			mode_left = $urandom_range(30, 250);
		end else begin
			mode_left = mode_left - 1;
		end
		stall_phase = stall_phase + 4'd1;
		case (stall_mode)
		STALL_NONE: out_stall <= 1'b0;
		STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
		default: out_stall <= (stall_phase < 4'd9);
		endcase
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value %h row %0d col %0d status %0b",
					         out_item.result_value, out_item.result_row,
					         out_item.result_column, out_item.status);
			end else begin
				wanted = pending_results.pop_front();
				checked_count++;
				if (out_item.result_value !== wanted.result_value ||
				    out_item.result_row !== wanted.result_row ||
				    out_item.result_column !== wanted.result_column ||
				    out_item.status !== wanted.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp %h r%0d c%0d s%0b, got %h r%0d c%0d s%0b",
						         wanted.result_value, wanted.result_row,
						         wanted.result_column, wanted.status,
						         out_item.result_value, out_item.result_row,
						         out_item.result_column, out_item.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic [4:0] phase_dims[$];
		int         d;
		int         roll;
		logic [1:0] load_op;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		dim_setting = 5'd16;
		for (int i = 0; i < smm_pkg::DEPTH; i++) begin
			left_elems[i] = '0;
			right_elems[i] = '0;
			left_loaded[i] = 1'b0;
			right_loaded[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero saturates to a 1x1 matrix
		directed_rows.push_back(dim_row(5'd0));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 0, 0, 32'h8000_0000));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_RIGHT, 0, 0, 32'h8000_0000));
		directed_rows.push_back(typed_row(0, 0, 64'h0000_4000_0000_0000, 1'b0));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 0, 0, 32'h7FFF_FFFF));
		directed_rows.push_back(typed_row(0, 0, 64'hFFFF_C000_0000_8000, 1'b0));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_RIGHT, 0, 0, 32'h7FFF_FFFF));
		directed_rows.push_back(typed_row(0, 0, 64'h0000_3FFF_FFFF_0000, 1'b0));
		// negative product floors to minus one ulp
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 0, 0, 32'hFFFF_FFFF));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_RIGHT, 0, 0, 32'h0000_0001));
		directed_rows.push_back(typed_row(0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
		// load outside the matrix is dropped, request outside is flagged
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 0, 1, 32'h1234_5678));
		directed_rows.push_back(typed_row(0, 1, 64'h0, 1'b1));
		directed_rows.push_back(typed_row(15, 15, 64'h0, 1'b1));
		directed_rows.push_back(item_row(OP_UNUSED, 15, 15, 32'hFFFF_FFFF));
		// grow to 2x2; the (0,0) entries keep their place
		directed_rows.push_back(dim_row(5'd2));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 0, 1, 32'h0001_8000));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 1, 0, 32'hFFFE_0000));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_LEFT, 1, 1, 32'h7FFF_FFFF));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_RIGHT, 1, 0, 32'h8000_0000));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_RIGHT, 0, 1, 32'h0000_4000));
		directed_rows.push_back(item_row(smm_pkg::OP_LOAD_RIGHT, 1, 1, 32'hFFFF_8001));
		directed_rows.push_back(item_row(smm_pkg::OP_COMPUTE, 1, 1, 32'h0));
		directed_rows.push_back(item_row(smm_pkg::OP_COMPUTE, 0, 0, 32'hFFFF_FFFF));
		directed_rows.push_back(typed_row(2, 1, 64'h0, 1'b1));
		directed_rows.push_back(typed_row(1, 2, 64'h0, 1'b1));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_DIM)
				set_dimension(directed_rows[i].dim);
			else
				push_item(directed_rows[i].item, directed_rows[i].typed,
				          directed_rows[i].result);
		end

		phase_dims = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd3, 5'd2, 5'd8};
		phase_dims.push_back(5'($urandom_range(17, 30)));
		phase_dims.push_back(5'($urandom_range(4, 15)));
		phase_dims.push_back(5'($urandom_range(1, 16)));
		phase_dims.push_back(5'd5);

		foreach (phase_dims[p]) begin
			set_dimension(phase_dims[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				d = eff_dim();
				roll = $urandom_range(0, 99);
				load_op = $urandom_range(0, 1) ? smm_pkg::OP_LOAD_RIGHT : smm_pkg::OP_LOAD_LEFT;
				if ($urandom_range(0, 49) == 0)
					quiesce();
				if (roll < 35)
					push_item(make_item(load_op,
					                    $urandom_range(0, d - 1), $urandom_range(0, d - 1),
					                    rand_element()), 1'b0, '0);
				else if (roll < 45)
					push_item(make_item(load_op,
					                    $urandom_range(0, 15), $urandom_range(0, 15),
					                    rand_element()), 1'b0, '0);
				else if (roll < 85)
					request_element($urandom_range(0, d - 1), $urandom_range(0, d - 1));
				else if (roll < 93)
					request_element($urandom_range(0, 15), $urandom_range(0, 15));
				else
					push_item(make_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
					                    $urandom), 1'b0, '0);
			end
		end

		quiesce();
		$display("ran %0d loads, %0d result requests (%0d outside the matrix), %0d unused opcodes",
		         load_count, request_count, outside_count, unused_count);
		$display("over %0d dimension settings; %0d results checked, %0d failures, %0d left over",
		         dim_count, checked_count, fail_count, pending_results.size());
		if (fail_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- square_matrix_multiply_core.f -----
rtl/smm_pkg.sv
rtl/smm_ctrl.sv
rtl/smm_datapath.sv
rtl/square_matrix_multiply_core.sv
sim/tb.sv
